>>> hw/rtl/mkd_pkg.sv
// Shared types, constants and the character table of the keying decoder.
`default_nettype none
package mkd_pkg;

    // One classified magnitude as it travels from the front end to the back end.
    typedef struct packed {
        logic [31:0] now_ms;
        logic        raw_key;
    } q_item_t;

    // Request to the shared divider. With by_three set the divisor is ignored
    // and the dividend is divided by three through the reciprocal path.
    typedef struct packed {
        logic        start;
        logic        by_three;
        logic [33:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    // Answer from the shared divider.
    typedef struct packed {
        logic        busy;
        logic        done;
        logic [33:0] quotient;
    } div_rsp_t;

    localparam logic [15:0] FLOOR_RESET     = 16'd100;
    localparam logic [7:0]  BLANK_RESET     = 8'd6;
    localparam logic [15:0] THRESHOLD_RESET = 16'd100;

    // floor(x / 6) == (x * RECIP6) >> RECIP6_SHIFT for every x below 2^19.
    localparam logic [18:0] RECIP6       = 19'd349526;
    localparam int          RECIP6_SHIFT = 21;

    // floor(x / 3) == (x * 34'h2AAAAAAAB) >> 35 for every x below 2^35. The
    // reciprocal is split into two 17-bit halves, one multiply per cycle.
    localparam logic [16:0] RECIP3_LO   = 17'h0AAAB;
    localparam logic [16:0] RECIP3_HI   = 17'h15555;
    localparam logic [5:0]  RECIP_STEPS = 6'd3;

    localparam logic [31:0] DIV_BY_THREE = 32'd3;
    localparam logic [33:0] SPEED_NUMER  = 34'd1200;
    localparam logic [5:0]  DIV_STEPS    = 6'd34;

    // Speed limits that widen the gap factor, and the gap factors in tenths
    // already multiplied by two (letter gap) and by five (word gap).
    localparam logic [10:0] SPEED_MID  = 11'd30;
    localparam logic [10:0] SPEED_FAST = 11'd35;
    localparam logic [6:0]  LGAP_SLOW  = 7'd20;
    localparam logic [6:0]  LGAP_MID   = 7'd24;
    localparam logic [6:0]  LGAP_FAST  = 7'd30;
    localparam logic [6:0]  WGAP_SLOW  = 7'd50;
    localparam logic [6:0]  WGAP_MID   = 7'd60;
    localparam logic [6:0]  WGAP_FAST  = 7'd75;

    localparam logic [1:0] ELEM_NONE = 2'd0;
    localparam logic [1:0] ELEM_DOT  = 2'd1;
    localparam logic [1:0] ELEM_DASH = 2'd2;

    // Look up a pattern of one to seven elements, dash = 1, first element in
    // the highest used bit. Returns 0 when the pattern is not a character.
    function automatic logic [6:0] morse_ascii(input logic [2:0] len, input logic [6:0] bits);
        logic [6:0] ch;
        ch = 7'd0;
        unique case ({len, bits})
            {3'd2, 7'b0000001}: ch = 7'd65;
            {3'd4, 7'b0001000}: ch = 7'd66;
            {3'd4, 7'b0001010}: ch = 7'd67;
            {3'd3, 7'b0000100}: ch = 7'd68;
            {3'd1, 7'b0000000}: ch = 7'd69;
            {3'd4, 7'b0000010}: ch = 7'd70;
            {3'd3, 7'b0000110}: ch = 7'd71;
            {3'd4, 7'b0000000}: ch = 7'd72;
            {3'd2, 7'b0000000}: ch = 7'd73;
            {3'd4, 7'b0000111}: ch = 7'd74;
            {3'd3, 7'b0000101}: ch = 7'd75;
            {3'd4, 7'b0000100}: ch = 7'd76;
            {3'd2, 7'b0000011}: ch = 7'd77;
            {3'd2, 7'b0000010}: ch = 7'd78;
            {3'd3, 7'b0000111}: ch = 7'd79;
            {3'd4, 7'b0000110}: ch = 7'd80;
            {3'd4, 7'b0001101}: ch = 7'd81;
            {3'd3, 7'b0000010}: ch = 7'd82;
            {3'd3, 7'b0000000}: ch = 7'd83;
            {3'd1, 7'b0000001}: ch = 7'd84;
            {3'd3, 7'b0000001}: ch = 7'd85;
            {3'd4, 7'b0000001}: ch = 7'd86;
            {3'd3, 7'b0000011}: ch = 7'd87;
            {3'd4, 7'b0001001}: ch = 7'd88;
            {3'd4, 7'b0001011}: ch = 7'd89;
            {3'd4, 7'b0001100}: ch = 7'd90;
            {3'd5, 7'b0001111}: ch = 7'd49;
            {3'd5, 7'b0000111}: ch = 7'd50;
            {3'd5, 7'b0000011}: ch = 7'd51;
            {3'd5, 7'b0000001}: ch = 7'd52;
            {3'd5, 7'b0000000}: ch = 7'd53;
            {3'd5, 7'b0010000}: ch = 7'd54;
            {3'd5, 7'b0011000}: ch = 7'd55;
            {3'd5, 7'b0011100}: ch = 7'd56;
            {3'd5, 7'b0011110}: ch = 7'd57;
            {3'd5, 7'b0011111}: ch = 7'd48;
            {3'd6, 7'b0001100}: ch = 7'd63;
            {3'd6, 7'b0010101}: ch = 7'd46;
            {3'd6, 7'b0110011}: ch = 7'd44;
            {3'd6, 7'b0101011}: ch = 7'd33;
            {3'd6, 7'b0011010}: ch = 7'd64;
            {3'd6, 7'b0111000}: ch = 7'd58;
            {3'd6, 7'b0100001}: ch = 7'd45;
            {3'd5, 7'b0010010}: ch = 7'd47;
            {3'd5, 7'b0010110}: ch = 7'd40;
            {3'd6, 7'b0101101}: ch = 7'd41;
            {3'd5, 7'b0001000}: ch = 7'd95;
            {3'd7, 7'b0001001}: ch = 7'd36;
            {3'd6, 7'b0000101}: ch = 7'd62;
            {3'd5, 7'b0001010}: ch = 7'd60;
            {3'd5, 7'b0000010}: ch = 7'd126;
            default:            ch = 7'd0;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/mkd_if.sv
// Valid/ready channel interfaces for magnitude requests and decoded results.
`default_nettype none
interface mkd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic [15:0] magnitude;
    modport source (output valid, output now_ms, output magnitude, input ready);
    modport sink   (input valid, input now_ms, input magnitude, output ready);
endinterface

interface mkd_out_if;
    logic        valid;
    logic        ready;
    logic        keyed;
    logic [1:0]  element;
    logic        letter_valid;
    logic [6:0]  letter;
    logic        space_valid;
    logic [10:0] words_per_minute;
    modport source (output valid, output keyed, output element, output letter_valid,
                    output letter, output space_valid, output words_per_minute, input ready);
    modport sink   (input valid, input keyed, input element, input letter_valid,
                    input letter, input space_valid, input words_per_minute, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/mkd_front.sv
// Front end: adaptive threshold and raw key decision for each magnitude.
`default_nettype none
module mkd_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    mkd_in_if.sink               in_ch,
    input  wire logic [15:0]     magnitude_floor,
    output mkd_pkg::q_item_t     push_item,
    output logic                 push_valid,
    input  wire logic            push_ready
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [15:0] thr_reg, thr_next;
    logic [31:0] now_reg, now_next;
    logic [15:0] mag_reg, mag_next;
    logic [37:0] prod_reg, prod_next;
    logic [18:0] sum;
    logic [15:0] quot, thr_upd, thr_new;
    logic        raw_key;

    assign sum     = 19'({thr_reg, 2'b00}) + 19'(thr_reg) + 19'(mag_reg);
    assign quot    = prod_reg[mkd_pkg::RECIP6_SHIFT +: 16];
    assign thr_upd = (mag_reg > magnitude_floor) ? quot : thr_reg;
    assign thr_new = (thr_upd < magnitude_floor) ? magnitude_floor : thr_upd;
    assign raw_key = (20'(mag_reg) * 20'd10) > (20'(thr_new) * 20'd6);

    assign in_ch.ready       = (state_reg == F_IDLE);
    assign push_valid        = (state_reg == F_PUSH);
    assign push_item.now_ms  = now_reg;
    assign push_item.raw_key = raw_key;

    always_comb
    begin
        state_next = state_reg;
        thr_next   = thr_reg;
        now_next   = now_reg;
        mag_next   = mag_reg;
        prod_next  = prod_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_ch.valid)
                begin
                    now_next   = in_ch.now_ms;
                    mag_next   = in_ch.magnitude;
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                prod_next  = 38'(sum) * 38'(mkd_pkg::RECIP6);
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    thr_next   = thr_new;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            thr_reg   <= mkd_pkg::THRESHOLD_RESET;
        end
        else
        begin
            state_reg <= state_next;
            thr_reg   <= thr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg  <= now_next;
        mag_reg  <= mag_next;
        prod_reg <= prod_next;
    end

endmodule
`default_nettype wire

>>> hw/rtl/mkd_queue.sv
// Two-entry queue between the front end and the back end.
`default_nettype none
module mkd_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  mkd_pkg::q_item_t      push_item,
    input  wire logic             push_valid,
    output logic                  push_ready,
    output mkd_pkg::q_item_t      pop_item,
    output logic                  pop_valid,
    input  wire logic             pop_ready
);

    mkd_pkg::q_item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/mkd_div.sv
// Shared divider: restoring, one quotient bit per cycle, with a short reciprocal path for thirds.
`default_nettype none
module mkd_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  mkd_pkg::div_req_t     req,
    output mkd_pkg::div_rsp_t     rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [33:0] quo_reg, quo_next;
    logic [31:0] dsr_reg, dsr_next;
    logic        recip_reg, recip_next;
    logic [50:0] plo_reg, plo_next;
    logic [50:0] phi_reg, phi_next;
    logic [32:0] rem_sh;
    logic        fits;
    logic [67:0] prod_sum;

    assign rem_sh = {rem_reg, quo_reg[33]};
    assign fits   = rem_sh >= {1'b0, dsr_reg};

    // Full product of the dividend and the reciprocal of three.
    assign prod_sum = {phi_reg, 17'd0} + 68'(plo_reg);

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dsr_next   = dsr_reg;
        recip_next = recip_reg;
        plo_next   = plo_reg;
        phi_next   = phi_reg;
        if (busy_reg)
        begin
            if (recip_reg)
            begin
                if (cnt_reg == 6'd3)
                begin
                    plo_next = 51'(quo_reg) * 51'(mkd_pkg::RECIP3_LO);
                end
                else if (cnt_reg == 6'd2)
                begin
                    phi_next = 51'(quo_reg) * 51'(mkd_pkg::RECIP3_HI);
                end
                else
                begin
                    quo_next = 34'(prod_sum[67:35]);
                end
            end
            else
            begin
                rem_next = fits ? 32'(rem_sh - {1'b0, dsr_reg}) : rem_sh[31:0];
                quo_next = {quo_reg[32:0], fits};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next  = 1'b1;
            recip_next = req.by_three;
            cnt_next   = req.by_three ? mkd_pkg::RECIP_STEPS : mkd_pkg::DIV_STEPS;
            rem_next   = 32'd0;
            quo_next   = req.dividend;
            dsr_next   = req.divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dsr_reg   <= dsr_next;
        recip_reg <= recip_next;
        plo_reg   <= plo_next;
        phi_reg   <= phi_next;
    end

endmodule
`default_nettype wire

>>> hw/rtl/mkd_back.sv
// Back end: noise blanker, timing, element sorting, speed and character decode.
`default_nettype none
module mkd_back #(
    parameter int MAX_ELEMENTS = 7
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  mkd_pkg::q_item_t      pop_item,
    input  wire logic             pop_valid,
    output logic                  pop_ready,
    input  wire logic [7:0]       blank_ms,
    output mkd_pkg::div_req_t     div_req,
    input  mkd_pkg::div_rsp_t     div_rsp,
    mkd_out_if.source             out_ch
);

    localparam int LW = $clog2(MAX_ELEMENTS + 1);

    localparam logic [3:0] B_IDLE   = 4'd0;
    localparam logic [3:0] B_KEY    = 4'd1;
    localparam logic [3:0] B_AVG1   = 4'd2;
    localparam logic [3:0] B_AVGDIV = 4'd3;
    localparam logic [3:0] B_AVG2   = 4'd4;
    localparam logic [3:0] B_CLS    = 4'd5;
    localparam logic [3:0] B_THIRD  = 4'd6;
    localparam logic [3:0] B_SPD    = 4'd7;
    localparam logic [3:0] B_GAP    = 4'd8;

    logic [3:0]              state_reg, state_next;
    logic [31:0]             now_reg, now_next;
    logic                    raw_reg, raw_next;
    logic                    raw_before_reg, raw_before_next;
    logic                    clean_reg, clean_next;
    logic                    clean_before_reg, clean_before_next;
    logic [31:0]             rct_reg, rct_next;
    logic [31:0]             high_start_reg, high_start_next;
    logic [31:0]             low_start_reg, low_start_next;
    logic [31:0]             high_len_reg, high_len_next;
    logic [31:0]             low_len_reg, low_len_next;
    logic [31:0]             dit_avg_reg, dit_avg_next;
    logic [31:0]             avg_work_reg, avg_work_next;
    logic [10:0]             speed_reg, speed_next;
    logic [MAX_ELEMENTS-1:0] pat_bits_reg, pat_bits_next;
    logic [LW-1:0]           pat_len_reg, pat_len_next;
    logic                    pat_ovf_reg, pat_ovf_next;
    logic                    tmo_done_reg, tmo_done_next;
    logic                    last_space_reg, last_space_next;
    logic [1:0]              element_reg, element_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    out_keyed_reg, out_keyed_next;
    logic [1:0]              out_element_reg, out_element_next;
    logic                    out_lv_reg, out_lv_next;
    logic [6:0]              out_letter_reg, out_letter_next;
    logic                    out_sv_reg, out_sv_next;
    logic [10:0]             out_wpm_reg, out_wpm_next;

    logic        out_free;
    logic [31:0] rct_now;
    logic        clean_now;
    logic [32:0] hl_sat_sum;
    logic [6:0]  lgap, wgap;
    logic [39:0] ll10, lgap_lim, wgap_lim;
    logic        gap_mid, gap_word, tmo_hit, do_decode, found_ok;
    logic [15:0] pat16;
    logic [6:0]  found;
    logic        dash_adds;

    assign out_free  = !out_valid_reg || out_ch.ready;
    assign pop_ready = (state_reg == B_IDLE);

    // Blanker: a raw change restarts the hold timer.
    assign rct_now   = (raw_reg != raw_before_reg) ? now_reg : rct_reg;
    assign clean_now = ((now_reg - rct_now) > 32'(blank_ms)) ? raw_reg : clean_reg;

    assign hl_sat_sum = 33'(high_len_reg) + 33'(avg_work_reg);

    // Gap factors depend on the speed already updated for this request.
    assign lgap = (speed_reg > mkd_pkg::SPEED_FAST) ? mkd_pkg::LGAP_FAST :
                  (speed_reg > mkd_pkg::SPEED_MID)  ? mkd_pkg::LGAP_MID  : mkd_pkg::LGAP_SLOW;
    assign wgap = (speed_reg > mkd_pkg::SPEED_FAST) ? mkd_pkg::WGAP_FAST :
                  (speed_reg > mkd_pkg::SPEED_MID)  ? mkd_pkg::WGAP_MID  : mkd_pkg::WGAP_SLOW;
    assign ll10     = 40'(low_len_reg) * 40'd10;
    assign lgap_lim = 40'(dit_avg_reg) * 40'(lgap);
    assign wgap_lim = 40'(dit_avg_reg) * 40'(wgap);
    assign gap_mid  = clean_reg && (ll10 > lgap_lim) && (ll10 < wgap_lim);
    assign gap_word = clean_reg && (ll10 >= wgap_lim);
    assign tmo_hit  = ({3'b000, now_reg - low_start_reg} > (35'(high_len_reg) * 35'd6))
                      && !tmo_done_reg;
    assign do_decode = gap_mid || gap_word || tmo_hit;

    // A request decodes at most once, and that decode clears the pattern.
    assign pat16    = 16'(pat_bits_reg);
    assign found_ok = !pat_ovf_reg && (pat_len_reg != '0) && (5'(pat_len_reg) <= 5'd7);
    assign found    = found_ok ? mkd_pkg::morse_ascii(3'(pat_len_reg), pat16[6:0]) : 7'd0;

    assign dash_adds = pat_len_reg < LW'(MAX_ELEMENTS);

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.keyed            = out_keyed_reg;
    assign out_ch.element          = out_element_reg;
    assign out_ch.letter_valid     = out_lv_reg;
    assign out_ch.letter           = out_letter_reg;
    assign out_ch.space_valid      = out_sv_reg;
    assign out_ch.words_per_minute = out_wpm_reg;

    always_comb
    begin
        state_next        = state_reg;
        now_next          = now_reg;
        raw_next          = raw_reg;
        raw_before_next   = raw_before_reg;
        clean_next        = clean_reg;
        clean_before_next = clean_before_reg;
        rct_next          = rct_reg;
        high_start_next   = high_start_reg;
        low_start_next    = low_start_reg;
        high_len_next     = high_len_reg;
        low_len_next      = low_len_reg;
        dit_avg_next      = dit_avg_reg;
        avg_work_next     = avg_work_reg;
        speed_next        = speed_reg;
        pat_bits_next     = pat_bits_reg;
        pat_len_next      = pat_len_reg;
        pat_ovf_next      = pat_ovf_reg;
        tmo_done_next     = tmo_done_reg;
        last_space_next   = last_space_reg;
        element_next      = element_reg;
        out_valid_next    = out_ch.ready ? 1'b0 : out_valid_reg;
        out_keyed_next    = out_keyed_reg;
        out_element_next  = out_element_reg;
        out_lv_next       = out_lv_reg;
        out_letter_next   = out_letter_reg;
        out_sv_next       = out_sv_reg;
        out_wpm_next      = out_wpm_reg;
        div_req.start     = 1'b0;
        div_req.by_three  = 1'b0;
        div_req.dividend  = 34'(high_len_reg);
        div_req.divisor   = mkd_pkg::DIV_BY_THREE;

        unique case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    now_next     = pop_item.now_ms;
                    raw_next     = pop_item.raw_key;
                    element_next = mkd_pkg::ELEM_NONE;
                    state_next   = B_KEY;
                end
            end
            B_KEY:
            begin
                rct_next          = rct_now;
                clean_next        = clean_now;
                raw_before_next   = raw_reg;
                clean_before_next = clean_now;
                state_next        = B_GAP;
                if (clean_now != clean_before_reg)
                begin
                    tmo_done_next = 1'b0;
                    if (clean_now)
                    begin
                        high_start_next = now_reg;
                        low_len_next    = now_reg - low_start_reg;
                    end
                    else
                    begin
                        low_start_next = now_reg;
                        high_len_next  = now_reg - high_start_reg;
                        state_next     = B_AVG1;
                    end
                end
            end
            B_AVG1:
            begin
                if ((33'(high_len_reg) < {dit_avg_reg, 1'b0}) || (dit_avg_reg == 32'd0))
                begin
                    div_req.start    = 1'b1;
                    div_req.by_three = 1'b1;
                    div_req.dividend = 34'(high_len_reg) + 34'({dit_avg_reg, 1'b0});
                    state_next       = B_AVGDIV;
                end
                else
                begin
                    avg_work_next = dit_avg_reg;
                    state_next    = B_AVG2;
                end
            end
            B_AVGDIV:
            begin
                if (div_rsp.done)
                begin
                    avg_work_next = div_rsp.quotient[31:0];
                    state_next    = B_AVG2;
                end
            end
            B_AVG2:
            begin
                if (35'(high_len_reg) > (35'(avg_work_reg) * 35'd5))
                begin
                    dit_avg_next = hl_sat_sum[32] ? '1 : hl_sat_sum[31:0];
                end
                else
                begin
                    dit_avg_next = avg_work_reg;
                end
                state_next = B_CLS;
            end
            B_CLS:
            begin
                state_next = B_GAP;
                if ((33'(high_len_reg) < {dit_avg_reg, 1'b0}) &&
                    ((36'(high_len_reg) * 36'd10) > (36'(dit_avg_reg) * 36'd6)))
                begin
                    element_next = mkd_pkg::ELEM_DOT;
                    if (dash_adds)
                    begin
                        pat_bits_next = {pat_bits_reg[MAX_ELEMENTS-2:0], 1'b0};
                        pat_len_next  = pat_len_reg + LW'(1);
                    end
                    else
                    begin
                        pat_ovf_next = 1'b1;
                    end
                end
                else if ((33'(high_len_reg) > {dit_avg_reg, 1'b0}) &&
                         (35'(high_len_reg) < (35'(dit_avg_reg) * 35'd6)))
                begin
                    element_next     = mkd_pkg::ELEM_DASH;
                    div_req.start    = 1'b1;
                    div_req.by_three = 1'b1;
                    state_next       = B_THIRD;
                    if (dash_adds)
                    begin
                        pat_bits_next = {pat_bits_reg[MAX_ELEMENTS-2:0], 1'b1};
                        pat_len_next  = pat_len_reg + LW'(1);
                    end
                    else
                    begin
                        pat_ovf_next = 1'b1;
                    end
                end
            end
            B_THIRD:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient != 34'd0)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = mkd_pkg::SPEED_NUMER;
                        div_req.divisor  = div_rsp.quotient[31:0];
                        state_next       = B_SPD;
                    end
                    else
                    begin
                        state_next = B_GAP;
                    end
                end
            end
            B_SPD:
            begin
                if (div_rsp.done)
                begin
                    speed_next = 11'((12'(speed_reg) + 12'(div_rsp.quotient[10:0])) >> 1);
                    state_next = B_GAP;
                end
            end
            B_GAP:
            begin
                if (out_free)
                begin
                    if (do_decode)
                    begin
                        pat_bits_next = '0;
                        pat_len_next  = '0;
                        pat_ovf_next  = 1'b0;
                    end
                    if (tmo_hit)
                    begin
                        tmo_done_next = 1'b1;
                    end
                    if (gap_word)
                    begin
                        last_space_next = 1'b1;
                    end
                    else if (do_decode && (found != 7'd0))
                    begin
                        last_space_next = 1'b0;
                    end
                    out_valid_next   = 1'b1;
                    out_keyed_next   = clean_reg;
                    out_element_next = element_reg;
                    out_lv_next      = do_decode && (found != 7'd0);
                    out_letter_next  = do_decode ? found : 7'd0;
                    out_sv_next      = gap_word && !(last_space_reg && (found == 7'd0));
                    out_wpm_next     = speed_reg;
                    state_next       = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            raw_before_reg   <= 1'b0;
            clean_reg        <= 1'b0;
            clean_before_reg <= 1'b0;
            rct_reg          <= 32'd0;
            high_start_reg   <= 32'd0;
            low_start_reg    <= 32'd0;
            high_len_reg     <= 32'd0;
            low_len_reg      <= 32'd0;
            dit_avg_reg      <= 32'd0;
            speed_reg        <= 11'd0;
            pat_bits_reg     <= '0;
            pat_len_reg      <= '0;
            pat_ovf_reg      <= 1'b0;
            tmo_done_reg     <= 1'b0;
            last_space_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            raw_before_reg   <= raw_before_next;
            clean_reg        <= clean_next;
            clean_before_reg <= clean_before_next;
            rct_reg          <= rct_next;
            high_start_reg   <= high_start_next;
            low_start_reg    <= low_start_next;
            high_len_reg     <= high_len_next;
            low_len_reg      <= low_len_next;
            dit_avg_reg      <= dit_avg_next;
            speed_reg        <= speed_next;
            pat_bits_reg     <= pat_bits_next;
            pat_len_reg      <= pat_len_next;
            pat_ovf_reg      <= pat_ovf_next;
            tmo_done_reg     <= tmo_done_next;
            last_space_reg   <= last_space_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg         <= now_next;
        raw_reg         <= raw_next;
        avg_work_reg    <= avg_work_next;
        element_reg     <= element_next;
        out_keyed_reg   <= out_keyed_next;
        out_element_reg <= out_element_next;
        out_lv_reg      <= out_lv_next;
        out_letter_reg  <= out_letter_next;
        out_sv_reg      <= out_sv_next;
        out_wpm_reg     <= out_wpm_next;
    end

endmodule
`default_nettype wire

>>> hw/rtl/morse_keying_decoder.sv
// Top level of the adaptive Morse keying decoder.
//
//   Channel   Direction  Payload
//   in_ch     sink       now_ms[31:0], magnitude[15:0]
//   out_ch    source     keyed, element[1:0], letter_valid, letter[6:0],
//                        space_valid, words_per_minute[10:0]
//   cfg       write      cfg_we, cfg_index (0 floor, 1 blank time), cfg_data[15:0]
//
// The front end takes a request in its idle state, multiplies the threshold sum by
// the reciprocal of six to divide it by six, and pushes the result; it takes no new
// request until that push is taken. The back end takes a request, updates the
// blanker and key timing, then checks the gap and writes the result. A falling edge
// adds the dit average update, rebuilt through the reciprocal divide by three when needed,
// and element sorting; a dash adds a divide by three and a serial division of 1200.
// Reset is asynchronous and active low and leaves the block ready at once.
// A two-entry queue lets the front end keep accepting while the back end or the
// result register waits; a full result register only stalls the back end.
`default_nettype none
module morse_keying_decoder #(
    parameter int MAX_ELEMENTS = 7
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    mkd_in_if.sink           in_ch,
    mkd_out_if.source        out_ch,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam logic REG_FLOOR = 1'b0;
    localparam logic REG_BLANK = 1'b1;

    logic [15:0] floor_reg, floor_next;
    logic [7:0]  blank_reg, blank_next;

    mkd_pkg::q_item_t  push_item, pop_item;
    logic              push_valid, push_ready, pop_valid, pop_ready;
    mkd_pkg::div_req_t div_req;
    mkd_pkg::div_rsp_t div_rsp;

    // Configuration writes land in plain registers; both are read by the datapath
    // during a request, so the user must write them only while idle; it is not enforced.
    always_comb
    begin
        floor_next = floor_reg;
        blank_next = blank_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FLOOR: floor_next = cfg_data;
                REG_BLANK: blank_next = cfg_data[7:0];
                default:   floor_next = floor_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= mkd_pkg::FLOOR_RESET;
            blank_reg <= mkd_pkg::BLANK_RESET;
        end
        else
        begin
            floor_reg <= floor_next;
            blank_reg <= blank_next;
        end
    end

    // Front end: threshold tracking and raw key decision.
    mkd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .magnitude_floor (floor_reg),
        .push_item       (push_item),
        .push_valid      (push_valid),
        .push_ready      (push_ready)
    );

    mkd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_item   (pop_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    // Back end: blanker, timing, element sorting and character decode.
    mkd_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_item  (pop_item),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .blank_ms  (blank_reg),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .out_ch    (out_ch)
    );

    mkd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule
`default_nettype wire
